### hdl/lsbse_pkg.sv
// Shared types and constants for the LSB steganography embed/extract unit.
package lsbse_pkg;

  // Item operation codes
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // Mode register values
  localparam logic MODE_EMBED   = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  // Configuration map
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;
  localparam logic        REG_MODE = 1'b0;  // register index, paddr[2]

  // Queue geometry
  localparam int unsigned QUEUE_W = 16;
  localparam int unsigned COUNT_W = 5;
  localparam logic [COUNT_W-1:0] BYTE_ROOM = 5'd8;   // max fill that still takes a byte

  // Working state of one embed or extract job
  typedef struct packed {
    logic [QUEUE_W-1:0] bit_queue;
    logic [COUNT_W-1:0] queued_bits;
    logic               terminator_seen;
    logic               done_flag;
    logic [7:0]         char_shift;
    logic [3:0]         char_bit_count;
  } state_t;

  // One input item
  typedef struct packed {
    logic       operation;
    logic [7:0] message_byte;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } item_t;

  // One result item
  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       char_valid;
    logic [7:0] char_value;
    logic       finished;
    logic       starved;
    logic       byte_rejected;
  } result_t;

endpackage

### hdl/lsbse_if.sv
// Stream interfaces for input items and result items.
interface lsbse_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] message_byte;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, operation, message_byte, red_in, green_in, blue_in,
                  input ready);
  modport sink   (input valid, operation, message_byte, red_in, green_in, blue_in,
                  output ready);
endinterface

interface lsbse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       char_valid;
  logic [7:0] char_value;
  logic       finished;
  logic       starved;
  logic       byte_rejected;

  modport source (output valid, red_out, green_out, blue_out, char_valid, char_value,
                  finished, starved, byte_rejected,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, char_valid, char_value,
                  finished, starved, byte_rejected,
                  output ready);
endinterface

### hdl/lsbse_step.sv
// Combinational step logic: next job state and result for one item.
module lsbse_step (
  input  logic             mode,
  input  lsbse_pkg::state_t cur,
  input  lsbse_pkg::item_t  item,
  output lsbse_pkg::state_t nxt,
  output lsbse_pkg::result_t res
);

  always_comb begin
    logic [7:0]                    ch [3];
    logic [lsbse_pkg::COUNT_W-1:0] qb;
    logic [lsbse_pkg::COUNT_W-1:0] idx;
    logic [7:0]                    sh;
    logic [3:0]                    cnt;
    logic                          stop;
    logic                          cvalid;
    logic [7:0]                    cval;

    nxt    = cur;
    ch[0]  = item.red_in;
    ch[1]  = item.green_in;
    ch[2]  = item.blue_in;
    qb     = cur.queued_bits;
    idx    = '0;
    sh     = cur.char_shift;
    cnt    = cur.char_bit_count;
    stop   = 1'b0;
    cvalid = 1'b0;
    cval   = '0;
    res    = '0;

    if (item.operation == lsbse_pkg::OP_BYTE) begin
      // Message byte: queue it MSB first unless the job cannot take it
      ch[0] = '0;
      ch[1] = '0;
      ch[2] = '0;
      if (mode == lsbse_pkg::MODE_EXTRACT || cur.terminator_seen ||
          cur.queued_bits > lsbse_pkg::BYTE_ROOM) begin
        res.byte_rejected = 1'b1;
      end else begin
        nxt.bit_queue   = {cur.bit_queue[7:0], item.message_byte};
        nxt.queued_bits = cur.queued_bits + lsbse_pkg::BYTE_ROOM;
        if (item.message_byte == 8'd0) begin
          nxt.terminator_seen = 1'b1;
        end
      end
    end else if (cur.done_flag) begin
      // Job finished: pixel passes unchanged
    end else if (mode == lsbse_pkg::MODE_EMBED) begin
      // Embed: oldest queued bits replace R, G, B LSBs in turn
      if (cur.queued_bits >= 5'd3 || cur.terminator_seen) begin
        for (int k = 0; k < 3; k++) begin
          if (qb != '0) begin
            idx      = qb - 5'd1;
            ch[k][0] = cur.bit_queue[idx[3:0]];
            qb       = qb - 5'd1;
          end
        end
        nxt.queued_bits = qb;
        if (cur.terminator_seen && qb == '0) begin
          nxt.done_flag = 1'b1;
        end
      end else begin
        res.starved = 1'b1;
      end
    end else begin
      // Extract: gather LSBs MSB first, stop at a zero character
      for (int k = 0; k < 3; k++) begin
        if (!stop) begin
          sh  = {sh[6:0], ch[k][0]};
          cnt = cnt + 4'd1;
          if (cnt == 4'd8) begin
            cnt = '0;
            if (sh == 8'd0) begin
              nxt.done_flag = 1'b1;
              stop          = 1'b1;
            end else begin
              cvalid = 1'b1;
              cval   = sh;
              sh     = '0;
            end
          end
        end
      end
      nxt.char_shift     = sh;
      nxt.char_bit_count = cnt;
    end

    res.red_out    = ch[0];
    res.green_out  = ch[1];
    res.blue_out   = ch[2];
    res.char_valid = cvalid;
    res.char_value = cval;
    res.finished   = nxt.done_flag;
  end

endmodule

### hdl/lsb_stego_embed_extract_unit.sv
// Top level of the LSB steganography embed/extract unit.
//
// Usage: write the mode register over APB (address 0, bit 0: 0 embeds,
// 1 extracts); every mode write also starts a fresh job. Items arrive on
// in_ch: operation 0 carries a message byte, operation 1 carries an RGB888
// pixel in raster order. Each accepted item gives exactly one result on
// out_ch: the pixel with message bits in the R, G, B LSBs (embed), the
// pixel plus any completed character (extract), and the finished, starved
// and byte_rejected flags.
// Result valid rises in the cycle after the input transfer. Throughput
// is one item per clock while the receiver keeps up; the step logic is a
// single combinational pass from job state and input to output register.
// When the receiver stalls, the result holds in the output register and
// in_ch.ready drops until it is taken; a new item is taken in the same
// cycle the waiting result is transferred.
// Reset (rst, synchronous) selects embed mode, clears the job state and
// empties the output register.
module lsb_stego_embed_extract_unit (
  input  logic                               clk,
  input  logic                               rst,
  lsbse_in_if.sink                           in_ch,
  lsbse_out_if.source                        out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lsbse_pkg::ADDR_W-1:0]       paddr,
  input  logic [lsbse_pkg::DATA_W-1:0]       pwdata,
  output logic [lsbse_pkg::DATA_W-1:0]       prdata,
  output logic                               pready
);

  logic                mode;
  lsbse_pkg::state_t   state;
  lsbse_pkg::state_t   state_next;
  lsbse_pkg::item_t    item;
  lsbse_pkg::result_t  res_next;
  lsbse_pkg::result_t  res;
  logic                out_valid;
  logic                in_take;
  logic                cfg_write;

  // APB write decode
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == lsbse_pkg::REG_MODE);
  assign prdata    = (paddr[2] == lsbse_pkg::REG_MODE) ?
                     {{(lsbse_pkg::DATA_W-1){1'b0}}, mode} : '0;

  // Input transfer whenever the output register is free or draining
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_take     = in_ch.valid && in_ch.ready;

  assign item.operation    = in_ch.operation;
  assign item.message_byte = in_ch.message_byte;
  assign item.red_in       = in_ch.red_in;
  assign item.green_in     = in_ch.green_in;
  assign item.blue_in      = in_ch.blue_in;

  lsbse_step u_step (
    .mode (mode),
    .cur  (state),
    .item (item),
    .nxt  (state_next),
    .res  (res_next)
  );

  // Mode register and job state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= lsbse_pkg::MODE_EMBED;
      state <= '0;
    end else if (cfg_write) begin
      mode  <= pwdata[0];
      state <= '0;
    end else if (in_take) begin
      state <= state_next;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      res <= res_next;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.red_out       = res.red_out;
  assign out_ch.green_out     = res.green_out;
  assign out_ch.blue_out      = res.blue_out;
  assign out_ch.char_valid    = res.char_valid;
  assign out_ch.char_value    = res.char_value;
  assign out_ch.finished      = res.finished;
  assign out_ch.starved       = res.starved;
  assign out_ch.byte_rejected = res.byte_rejected;

endmodule

### hdl/lsbse_checker.sv
// Port-level checker for the LSB steganography unit, bound to the top level.
module lsbse_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red_out,
  input logic [7:0] char_value,
  input logic       char_valid,
  input logic       starved,
  input logic       byte_rejected
);

  // A stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red_out) && $stable(char_value))
    else $error("stalled result changed");

  // No new transfer while a result is stuck in the output register
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input ready while output stalled");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // A presented character is never the terminator
  a_char_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && char_valid |-> char_value != 8'd0)
    else $error("zero character presented");

  // Pixel-only and byte-only flags never meet
  a_flag_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_rejected |-> !starved && !char_valid)
    else $error("byte flag with pixel flag");

endmodule

bind lsb_stego_embed_extract_unit lsbse_checker u_lsbse_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .red_out       (out_ch.red_out),
  .char_value    (out_ch.char_value),
  .char_valid    (out_ch.char_valid),
  .starved       (out_ch.starved),
  .byte_rejected (out_ch.byte_rejected)
);
